/* sv/anb_pkg.sv */
// package for the annex b nal splitter: item types, parser state and the
// per-byte push and close functions; no dependencies
package anb_pkg;

	localparam int LIMIT_W = 21;
	localparam logic [LIMIT_W-1:0] MAX_UNIT_BYTES = LIMIT_W'(1048576);
	localparam int Q_DEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;
	localparam int MAX_RESULTS = 4;
	localparam logic [4:0] TYPE_MASK = 5'h1F;
	localparam logic [4:0] TYPE_IDR = 5'd5;
	localparam logic [4:0] TYPE_SPS = 5'd7;
	localparam logic [4:0] TYPE_PPS = 5'd8;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       end_of_stream;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] nal_byte;
		logic       first_of_nal;
		logic       last_of_nal;
		logic [4:0] unit_type;
		logic       key_unit;
		logic       truncated;
	} nal_item_t;

	typedef struct packed {
		logic [1:0]         zero_run;
		logic [1:0]         zero_hold_count;
		logic               inside_unit;
		logic               pending_valid;
		logic [7:0]         pending_data;
		logic               pending_is_first;
		logic [LIMIT_W-1:0] unit_byte_count;
		logic [4:0]         current_type;
		logic               current_key;
		logic               dropped_flag;
	} parse_st_t;

	typedef struct packed {
		parse_st_t st;
		logic      emit;
		nal_item_t item;
	} step_res_t;

	// item built from the pending byte
	function automatic nal_item_t pending_item(input parse_st_t s, input logic last);
		nal_item_t it;
		it.nal_byte     = s.pending_data;
		it.first_of_nal = s.pending_is_first;
		it.last_of_nal  = last;
		it.unit_type    = s.current_type & TYPE_MASK;
		it.key_unit     = s.current_key;
		it.truncated    = last & s.dropped_flag;
		return it;
	endfunction

	// one payload byte into the open unit
	function automatic step_res_t push_byte(input parse_st_t s, input logic [7:0] b,
			input logic [LIMIT_W-1:0] lim);
		step_res_t r;
		logic [4:0] ty;
		r.st   = s;
		r.emit = 1'b0;
		r.item = pending_item(s, 1'b0);
		ty     = b[4:0] & TYPE_MASK;
		if (s.inside_unit) begin
			if (s.unit_byte_count >= lim) begin
				r.st.dropped_flag = 1'b1;
			end else begin
				r.emit = s.pending_valid;
				r.st.pending_data = b;
				r.st.pending_is_first = (s.unit_byte_count == '0);
				if (s.unit_byte_count == '0) begin
					r.st.current_type = ty;
					r.st.current_key = (ty == TYPE_IDR) || (ty == TYPE_SPS) ||
						(ty == TYPE_PPS);
				end
				r.st.pending_valid = 1'b1;
				r.st.unit_byte_count = s.unit_byte_count + LIMIT_W'(1);
			end
		end
		return r;
	endfunction

	// end the open unit, flushing the pending byte as its last
	function automatic step_res_t close_unit(input parse_st_t s);
		step_res_t r;
		r.st   = s;
		r.emit = s.pending_valid;
		r.item = pending_item(s, 1'b1);
		r.st.pending_valid    = 1'b0;
		r.st.pending_data     = '0;
		r.st.pending_is_first = 1'b0;
		r.st.inside_unit      = 1'b0;
		r.st.zero_hold_count  = '0;
		r.st.unit_byte_count  = '0;
		r.st.dropped_flag     = 1'b0;
		return r;
	endfunction

endpackage

/* sv/annexb_nal_splitter.sv */
// top level of the annex b start-code splitter: parser state, limit register
// and an eight-deep result queue; depends on anb_pkg
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------
//  byte in   | byte_valid / byte_stall   | byte_item  (byte_item_t)
//  nal out   | nal_valid  / nal_stall    | nal_item   (nal_item_t)
//  limit cfg | limit_we                  | limit_data (21 bit)
//
// one stream byte is taken per clock while byte_stall is low; each byte yields zero to four items,
// which go into the result queue in the same cycle
// byte_stall rises while the queue holds more than four items, so a steady
// stream of one item per byte runs at one byte per clock while nal_stall is low
// the queue drains one item per clock whenever nal_stall is low
// arst_n clears parser state, queue pointers and sets the limit to its maximum
module annexb_nal_splitter
	import anb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  byte_item_t         byte_item,
	output logic               nal_valid,
	input  logic               nal_stall,
	output nal_item_t          nal_item,
	input  logic               limit_we,
	input  logic [LIMIT_W-1:0] limit_data
);

	// parser state and effective limit
	parse_st_t          state_q;
	logic [LIMIT_W-1:0] lim_q;

	// result queue
	nal_item_t         queue_q [Q_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	logic      accept;
	logic      pop;
	parse_st_t st_nxt;
	step_res_t sr;
	nal_item_t res [MAX_RESULTS];
	logic [2:0] n_res;

	assign accept     = byte_valid & ~byte_stall;
	assign pop        = nal_valid & ~nal_stall;
	assign byte_stall = (count_q > QCNT_W'(Q_DEPTH - MAX_RESULTS));
	assign nal_valid  = (count_q != '0);
	assign nal_item   = queue_q[rptr_q];

	// limit register: zero acts as one, clamp to the maximum unit size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= MAX_UNIT_BYTES;
		end else if (limit_we) begin
			if (limit_data == '0)
				lim_q <= LIMIT_W'(1);
			else if (limit_data > MAX_UNIT_BYTES)
				lim_q <= MAX_UNIT_BYTES;
			else
				lim_q <= limit_data;
		end
	end

	// one byte of parsing: held zeros are replayed before a non-start-code byte,
	// end of stream closes whatever unit is still open
	always_comb begin
		st_nxt = state_q;
		n_res  = '0;
		sr     = '0;
		for (int k = 0; k < MAX_RESULTS; k++) res[k] = '0;

		if (byte_item.stream_byte == 8'h00) begin
			if (st_nxt.zero_run != 2'd3) st_nxt.zero_run = st_nxt.zero_run + 2'd1;
			if (st_nxt.inside_unit) begin
				if (st_nxt.zero_hold_count < 2'd2) begin
					st_nxt.zero_hold_count = st_nxt.zero_hold_count + 2'd1;
				end else begin
					// three zeros cannot sit inside a unit: close it here
					sr = close_unit(st_nxt);
					st_nxt = sr.st;
					if (sr.emit) begin
						res[n_res[1:0]] = sr.item;
						n_res = n_res + 3'd1;
					end
				end
			end
		end else if (byte_item.stream_byte == 8'h01 && st_nxt.zero_run >= 2'd2) begin
			// start code: trailing zeros belong to the prefix and are dropped
			if (st_nxt.inside_unit) begin
				sr = close_unit(st_nxt);
				st_nxt = sr.st;
				if (sr.emit) begin
					res[n_res[1:0]] = sr.item;
					n_res = n_res + 3'd1;
				end
			end
			st_nxt.inside_unit     = 1'b1;
			st_nxt.unit_byte_count = '0;
			st_nxt.dropped_flag    = 1'b0;
			st_nxt.zero_hold_count = '0;
			st_nxt.zero_run        = '0;
		end else begin
			if (st_nxt.zero_hold_count >= 2'd1) begin
				sr = push_byte(st_nxt, 8'h00, lim_q);
				st_nxt = sr.st;
				if (sr.emit) begin
					res[n_res[1:0]] = sr.item;
					n_res = n_res + 3'd1;
				end
			end
			if (state_q.zero_hold_count >= 2'd2) begin
				sr = push_byte(st_nxt, 8'h00, lim_q);
				st_nxt = sr.st;
				if (sr.emit) begin
					res[n_res[1:0]] = sr.item;
					n_res = n_res + 3'd1;
				end
			end
			sr = push_byte(st_nxt, byte_item.stream_byte, lim_q);
			st_nxt = sr.st;
			if (sr.emit) begin
				res[n_res[1:0]] = sr.item;
				n_res = n_res + 3'd1;
			end
			st_nxt.zero_hold_count = '0;
			st_nxt.zero_run        = '0;
		end

		if (byte_item.end_of_stream) begin
			if (st_nxt.inside_unit) begin
				sr = close_unit(st_nxt);
				st_nxt = sr.st;
				if (sr.emit) begin
					res[n_res[1:0]] = sr.item;
					n_res = n_res + 3'd1;
				end
			end
			st_nxt.zero_run        = '0;
			st_nxt.zero_hold_count = '0;
		end
	end

	// parser state and queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				state_q <= st_nxt;
				wptr_q  <= wptr_q + QPTR_W'(n_res);
			end
			if (pop) rptr_q <= rptr_q + QPTR_W'(1);
			count_q <= count_q + (accept ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				if (3'(k) < n_res) queue_q[wptr_q + QPTR_W'(k)] <= res[k];
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(Q_DEPTH))
		else $error("result queue overfilled");

	a_pending_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending_valid |-> state_q.inside_unit)
		else $error("pending byte held outside a unit");

	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.zero_hold_count <= 2'd2)
		else $error("more than two zeros held");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		nal_valid && nal_item.truncated |-> nal_item.last_of_nal)
		else $error("truncated flag on a byte that is not last");

	a_eos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_item.end_of_stream |=> !state_q.inside_unit && !state_q.pending_valid)
		else $error("unit left open after end of stream");

endmodule
